@@ rtl/core/cpr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the clock page replacement core.
// Has no dependencies; every other file of the core imports it.
package cpr_pkg;

  localparam int unsigned MaxFrames  = 256;
  localparam int unsigned FrameW     = $clog2(MaxFrames);
  localparam int unsigned CountW     = 9;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CountW-1:0] FramesReset = CountW'(MaxFrames);

  typedef enum logic {
    CprModeRef   = 1'b0,
    CprModeEvict = 1'b1
  } cpr_mode_e;

  typedef enum logic {
    CprIdle,
    CprSweep
  } cpr_state_e;

  typedef struct packed {
    cpr_mode_e         mode;
    logic [FrameW-1:0] frame;
  } cpr_item_t;

endpackage

@@ rtl/core/clock_page_replacement_core.sv @@
`timescale 1ns / 1ps
// Top level of the clock page replacement core: frame count register,
// front end, item queue and sweep engine. Uses cpr_pkg, cpr_front,
// cpr_queue and cpr_back.
//
//   channel   direction  signals                         role
//   s_axis    in         tvalid tready tdata tuser       reference / evict requests
//   m_axis    out        tvalid tready tdata             eviction victims
//   cfg       in         cfg_valid_i cfg_ready_o cfg_data_i  frames in use
//
// References stream at one per cycle while the sweep engine is idle. An
// eviction starts a sweep in which the hand visits 1 to frames_in_use + 1
// frames before it names a victim.
// Reset clears all reference bits and the hand at once; no clearing pass.
// A four-entry queue lets the front end keep taking transactions while the
// sweep engine runs or waits on m_axis_tready.
module clock_page_replacement_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] frame_index
  input  logic [0:0]                 s_axis_tuser,  // [0] mode
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [7:0] victim_frame
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cpr_pkg::CountW-1:0] cfg_data_i
);
  import cpr_pkg::*;

  logic [CountW-1:0] frames_q, frames_d, frames_eff;
  cpr_item_t         in_item, push_item, pop_item;
  logic              push_valid, push_ready, pop_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    frames_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : frames_q;
    if (frames_q == '0) begin
      frames_eff = CountW'(1);
    end else if (frames_q > CountW'(MaxFrames)) begin
      frames_eff = CountW'(MaxFrames);
    end else begin
      frames_eff = frames_q;
    end
    in_item.mode  = cpr_mode_e'(s_axis_tuser[0]);
    in_item.frame = s_axis_tdata[FrameW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FramesReset;
    end else begin
      frames_q <= frames_d;
    end
  end

  cpr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frames_i     (frames_eff),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  cpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  cpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frames_i    (frames_eff),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_item_i  (pop_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_frame_o (m_axis_tdata)
  );

endmodule

@@ rtl/core/cpr_front.sv @@
`timescale 1ns / 1ps
// Front end: takes input transactions, drops references outside the clock,
// and holds the classified item until the queue takes it. Uses cpr_pkg.
module cpr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cpr_pkg::CountW-1:0] frames_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cpr_pkg::cpr_item_t         in_item_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output cpr_pkg::cpr_item_t         push_item_o
);
  import cpr_pkg::*;

  logic      valid_q, valid_d;
  cpr_item_t item_q, item_d;
  logic      keep;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  always_comb begin
    keep = (in_item_i.mode == CprModeEvict) ||
           ({{(CountW - FrameW){1'b0}}, in_item_i.frame} < frames_i);
    valid_d = valid_q && !push_ready_i;
    item_d  = item_q;
    if (in_ready_o) begin
      valid_d = in_valid_i && keep;
      item_d  = in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ rtl/core/cpr_queue.sv @@
`timescale 1ns / 1ps
// Short first-in first-out queue of classified items between the front end
// and the sweep engine. Uses cpr_pkg.
module cpr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  cpr_pkg::cpr_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output cpr_pkg::cpr_item_t pop_item_o
);
  import cpr_pkg::*;

  cpr_item_t            entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/core/cpr_back.sv @@
`timescale 1ns / 1ps
// Back end, uses cpr_pkg: holds reference bits and the clock hand, applies
// references, sweeping for victims one frame per cycle with a free output.
module cpr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cpr_pkg::CountW-1:0] frames_i,
  input  logic                       pop_valid_i,
  output logic                       pop_o,
  input  cpr_pkg::cpr_item_t         pop_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cpr_pkg::FrameW-1:0] out_frame_o
);
  import cpr_pkg::*;

  cpr_state_e          state_q, state_d;
  logic [MaxFrames-1:0] bits_q, bits_d;
  logic [FrameW-1:0]   hand_q, hand_d, hand_next;
  logic [CountW-1:0]   hand_inc;
  logic                out_valid_q, out_valid_d;
  logic [FrameW-1:0]   out_frame_q, out_frame_d;
  logic                slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_frame_o = out_frame_q;

  always_comb begin
    hand_inc    = {{(CountW - FrameW){1'b0}}, hand_q} + CountW'(1);
    hand_next   = (hand_inc >= frames_i) ? '0 : hand_inc[FrameW-1:0];
    state_d     = state_q;
    hand_d      = hand_q;
    bits_d      = bits_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_frame_d = out_frame_q;
    pop_o       = 1'b0;
    case (state_q)
      CprIdle: begin
        if (pop_valid_i) begin
          pop_o = 1'b1;
          if (pop_item_i.mode == CprModeRef) begin
            bits_d[pop_item_i.frame] = 1'b1;
          end else begin
            state_d = CprSweep;
            if ({{(CountW - FrameW){1'b0}}, hand_q} >= frames_i) begin
              hand_d = '0;
            end
          end
        end
      end
      CprSweep: begin
        if (bits_q[hand_q]) begin
          bits_d[hand_q] = 1'b0;
          hand_d         = hand_next;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_frame_d = hand_q;
          hand_d      = hand_next;
          state_d     = CprIdle;
        end
      end
      default: begin
        state_d = CprIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CprIdle;
      bits_q      <= '0;
      hand_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bits_q      <= bits_d;
      hand_q      <= hand_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_frame_q <= out_frame_d;
  end

  a_sweep_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CprSweep && bits_q[hand_q]) |=> !bits_q[$past(hand_q)])
    else $error("sweep left a set reference bit in place");

  a_victim_is_hand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CprSweep && !bits_q[hand_q] && slot_free)
      |=> (out_valid_q && out_frame_q == $past(hand_q)))
    else $error("victim does not match the hand");

  a_hand_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CprSweep) |-> ({{(CountW - FrameW){1'b0}}, hand_q} < frames_i))
    else $error("hand outside the clock during a sweep");

endmodule

@@ tb/clock_page_replacement_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for clock_page_replacement_core: directed table, then random traffic
// with random stalls on both streams, checked against a second-chance clock predictor.
// Depends on cpr_pkg and the core RTL only.
module clock_page_replacement_core_test;
  import cpr_pkg::*;

  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldOffCycles = 500;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseItems = 63;
  localparam int unsigned PlanRows = 30;

  typedef enum logic {
    StepItem,
    StepCfg
  } step_kind_e;

  typedef struct packed {
    step_kind_e        kind;
    logic [CountW-1:0] frames;
    cpr_mode_e         mode;
    logic [7:0]        frame;
    logic              typed;
    logic [7:0]        victim;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;
  logic [0:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i;

  bit                page_used [MaxFrames];
  int unsigned       hand_at;
  logic [CountW-1:0] frames_cfg;
  logic [7:0]        victims_due [$];
  int unsigned       victims_taken = 0;
  int unsigned       errors = 0;

  plan_row_t plan [PlanRows] = '{
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b1, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd255, 1'b1, 8'd1},
    '{StepItem, 9'd0,   CprModeRef,   8'd3,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeRef,   8'd255, 1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b1, 8'd2},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b1, 8'd4},
    '{StepItem, 9'd0,   CprModeRef,   8'd0,   1'b0, 8'd0},
    '{StepCfg,  9'd0,   CprModeRef,   8'd0,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b1, 8'd0},
    '{StepItem, 9'd0,   CprModeRef,   8'd1,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd170, 1'b1, 8'd0},
    '{StepCfg,  9'd511, CprModeRef,   8'd0,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b1, 8'd0},
    '{StepItem, 9'd0,   CprModeRef,   8'd1,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeRef,   8'd2,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd85,  1'b1, 8'd3},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b0, 8'd0},
    '{StepCfg,  9'd2,   CprModeRef,   8'd0,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeRef,   8'd0,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeRef,   8'd1,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b1, 8'd0},
    '{StepCfg,  9'd255, CprModeRef,   8'd0,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeRef,   8'd255, 1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeRef,   8'd254, 1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b0, 8'd0},
    '{StepCfg,  9'd256, CprModeRef,   8'd0,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeRef,   8'd128, 1'b0, 8'd0},
    '{StepItem, 9'd0,   CprModeEvict, 8'd0,   1'b0, 8'd0}
  };

  clock_page_replacement_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned active_count();
    int unsigned n;
    n = frames_cfg;
    if (n == 0) n = 1;
    if (n > MaxFrames) n = MaxFrames;
    return n;
  endfunction

  // Second-chance sweep; returns 1 when the request yields a victim.
  function automatic bit pick_victim(input cpr_mode_e mode, input logic [7:0] frame,
                                     output logic [7:0] victim);
    int unsigned n;
    int unsigned h;
    int unsigned steps;
    bit found;
    n = active_count();
    victim = 8'd0;
    if (mode == CprModeRef) begin
      if (frame < n) page_used[frame] = 1'b1;
      return 1'b0;
    end
    if (hand_at >= n) hand_at = 0;
    found = 1'b0;
    for (steps = 0; steps <= 2 * n && !found; steps++) begin
      h = hand_at;
      hand_at = (h + 1 >= n) ? 0 : h + 1;
      if (page_used[h]) begin
        page_used[h] = 1'b0;
      end else begin
        victim = h[7:0];
        found = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request and records its expected victim once the transaction is accepted.
  task automatic offer_request(input cpr_mode_e mode, input logic [7:0] frame,
                               input logic typed, input logic [7:0] typed_victim);
    logic [7:0] victim;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= frame;
    do @(posedge clk_i); while (!s_axis_tready);
    if (pick_victim(mode, frame, victim)) begin
      victims_due.push_back(typed ? typed_victim : victim);
    end
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic set_frames(input logic [CountW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (victims_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    frames_cfg = value;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      victims_taken++;
      if (victims_due.size() == 0) begin
        $error("victim_frame: expected none, actual %0d", m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== victims_due[0]) begin
          $error("victim_frame: expected %0d, actual %0d", victims_due[0], m_axis_tdata);
          errors++;
        end
        void'(victims_due.pop_front());
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the input side fills up.
  initial begin
    int unsigned gap;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && victims_taken >= 40) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned k;
    logic [CountW-1:0] frames;
    cpr_mode_e mode;
    logic [7:0] frame;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    frames_cfg    = FramesReset;
    hand_at       = 0;
    for (k = 0; k < MaxFrames; k++) page_used[k] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < PlanRows; k++) begin
      if (plan[k].kind == StepCfg) begin
        set_frames(plan[k].frames);
      end else begin
        offer_request(plan[k].mode, plan[k].frame, plan[k].typed, plan[k].victim);
      end
    end

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: frames = 9'd1;
        1: frames = 9'd2;
        2: frames = 9'd3;
        3: frames = 9'd256;
        4: frames = 9'd255;
        5: frames = 9'd0;
        6: frames = 9'd511;
        7: frames = 9'($urandom_range(4, 40));
        8: frames = 9'($urandom_range(1, 256));
        default: frames = 9'($urandom_range(257, 511));
      endcase
      set_frames(frames);
      n = active_count();
      for (int i = 0; i < PhaseItems; i++) begin
        mode = ($urandom_range(0, 99) < 30) ? CprModeEvict : CprModeRef;
        if ($urandom_range(0, 99) < 85) frame = 8'($urandom_range(0, n - 1));
        else frame = 8'($urandom_range(0, 255));
        offer_request(mode, frame, 1'b0, 8'd0);
      end
    end

    s_axis_tvalid <= 1'b0;
    for (k = 0; k < 5000 && victims_due.size() != 0; k++) @(posedge clk_i);
    if (victims_due.size() != 0) begin
      $error("victim_frame: %0d expected results never arrived", victims_due.size());
      errors++;
    end
    repeat (4 * SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/cpr_pkg.sv
rtl/core/cpr_front.sv
rtl/core/cpr_queue.sv
rtl/core/cpr_back.sv
rtl/core/clock_page_replacement_core.sv
tb/clock_page_replacement_core_test.sv
